// File: sv/abkf_pkg.sv
// Package for the angle/bias Kalman filter: widths, register indexes,
// noise reset values and fixed-point helper functions. No dependencies.
`default_nettype none
package abkf_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW = 31;
  localparam int unsigned DtW = 16;
  localparam int unsigned IdxW = 2;
  localparam int unsigned QuoW = 48;

  localparam logic [IdxW-1:0] RegAngleNoise = 2'd0;
  localparam logic [IdxW-1:0] RegBiasNoise = 2'd1;
  localparam logic [IdxW-1:0] RegMeasNoise = 2'd2;

  localparam logic [CfgW-1:0] AngleNoiseReset = 31'd66;
  localparam logic [CfgW-1:0] BiasNoiseReset = 31'd197;
  localparam logic [CfgW-1:0] MeasNoiseReset = 31'd1966;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round product/2^16, ties toward plus infinity (arithmetic shift floor)
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
    logic signed [65:0] w;
    w = p + 66'sd32768;
    return w >>> 16;
  endfunction
endpackage
`default_nettype wire

// File: sv/abkf_if.sv
// Valid/ready channel interfaces for the angle/bias Kalman filter.
// No dependencies.
`default_nettype none
interface abkf_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic [15:0] time_step;
  modport source(output valid, measured_angle, gyro_rate, time_step, input ready);
  modport sink(input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface abkf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] filtered_angle;
  modport source(output valid, filtered_angle, input ready);
  modport sink(input valid, filtered_angle, output ready);
endinterface

interface abkf_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/angle_bias_kalman_filter.sv
// Two-state Kalman filter (angle, gyro bias) in Q16.16, one shared multiplier
// and one bit-serial divider under a step sequencer.
// An input transfer runs ten multiply steps and, between the prediction and
// the update, two divides; a zero divisor skips both divides.
// One item at a time. Reset: synchronous; clears estimates, covariance and
// restores noise regs.
`default_nettype none
module angle_bias_kalman_filter (
  input wire logic clk,
  input wire logic rst,
  abkf_in_if.sink   in_ch,
  abkf_out_if.source out_ch,
  abkf_cfg_if.sink  cfg
);
  import abkf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_WAIT = 9'b000000100,
    S_DIV0 = 9'b000001000,
    S_DW0  = 9'b000010000,
    S_DIV1 = 9'b000100000,
    S_DW1  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state;
  logic [4:0] step;

  logic [CfgW-1:0] q_angle, q_bias, r_meas;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, rate, tval, y, k0, k1, p00t, p01t;
  logic [15:0] dt;
  logic signed [32:0] s_val;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod, r;
  logic div_start, div_done;
  logic [63:0] div_num;
  logic [47:0] quo;
  logic signed [31:0] pnum;

  abkf_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));
  abkf_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num),
                  .den(s_val[32] ? 33'(-s_val) : s_val), .done(div_done), .quo(quo));

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.filtered_angle = ang;
  assign r = rnd16(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= AngleNoiseReset;
      q_bias  <= BiasNoiseReset;
      r_meas  <= MeasNoiseReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegAngleNoise: q_angle <= cfg.data[CfgW-1:0];
        RegBiasNoise:  q_bias  <= cfg.data[CfgW-1:0];
        RegMeasNoise:  r_meas  <= cfg.data[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // operand select for each multiply step
  always_comb begin
    ma = 33'(signed'({1'b0, dt}));
    mb = '0;
    case (step)
      5'd0: mb = 33'(rate);
      5'd1: mb = 33'(p11);
      5'd2: mb = 33'(tval);
      5'd3: mb = 33'(signed'({2'b0, q_bias}));
      5'd4: begin ma = 33'(k0); mb = 33'(y); end
      5'd5: begin ma = 33'(k1); mb = 33'(y); end
      5'd6: begin ma = 33'(k0); mb = 33'(p00t); end
      5'd7: begin ma = 33'(k0); mb = 33'(p01t); end
      5'd8: begin ma = 33'(k1); mb = 33'(p00t); end
      default: begin ma = 33'(k1); mb = 33'(p01t); end
    endcase
  end

  // signed gain from magnitude quotient, saturated
  function automatic logic signed [31:0] mkgain(input logic [47:0] q, input logic neg);
    logic [47:0] qc;
    qc = (q > 48'h80000000) ? 48'h80000000 : q;
    return sat32(neg ? -66'(signed'({1'b0, qc})) : 66'(signed'({1'b0, qc})));
  endfunction

  always_comb begin
    pnum = (state == S_DIV0) ? p00 : p10;
    div_num = {15'b0, (pnum[31] ? 33'(-33'(pnum)) : 33'(pnum)), 16'b0};
    div_start = (state == S_DIV0 || state == S_DIV1) && (s_val != 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      ang <= '0; bias <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          meas <= in_ch.measured_angle;
          dt <= in_ch.time_step;
          rate <= sat32(66'(in_ch.gyro_rate) - 66'(bias));
          step <= '0;
          state <= S_MUL;
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: begin
          step <= step + 5'd1;
          // divide after the prediction, present the result after the last update
          if (step == 5'd3) state <= S_DIV0;
          else if (step == 5'd9) state <= S_OUT;
          else state <= S_MUL;
          case (step)
            5'd0: ang <= sat32(66'(ang) + r);
            5'd1: begin
              tval <= sat32(r - 66'(p01) - 66'(p10) + 66'(signed'({1'b0, q_angle})));
              p01 <= sat32(66'(p01) - r);
              p10 <= sat32(66'(p10) - r);
            end
            5'd2: p00 <= sat32(66'(p00) + r);
            5'd3: begin
              p11 <= sat32(66'(p11) + r);
              s_val <= 33'(p00) + 33'(signed'({2'b0, r_meas}));
              y <= sat32(66'(meas) - 66'(ang));
            end
            5'd4: ang <= sat32(66'(ang) + r);
            5'd5: bias <= sat32(66'(bias) + r);
            5'd6: p00 <= sat32(66'(p00) - r);
            5'd7: p01 <= sat32(66'(p01) - r);
            5'd8: p10 <= sat32(66'(p10) - r);
            default: p11 <= sat32(66'(p11) - r);
          endcase
        end
        S_DIV0: begin
          p00t <= p00; p01t <= p01;
          k0 <= '0; k1 <= '0;
          state <= (s_val != 0) ? S_DW0 : S_MUL;
        end
        S_DW0: if (div_done) begin
          k0 <= mkgain(quo, p00[31] != s_val[32]);
          state <= S_DIV1;
        end
        S_DIV1: state <= S_DW1;
        S_DW1: if (div_done) begin
          k1 <= mkgain(quo, p10[31] != s_val[32]);
          state <= S_MUL;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/abkf_mul.sv
// Shared 33x33 signed multiplier with registered product.
// Depends on abkf_pkg.
`default_nettype none
module abkf_mul (
  input  wire logic                clk,
  input  wire logic signed [32:0]  a,
  input  wire logic signed [32:0]  b,
  output      logic signed [65:0]  prod
);
  import abkf_pkg::*;
  always_ff @(posedge clk) begin
    prod <= 66'(a) * 66'(b);
  end
endmodule
`default_nettype wire

// File: sv/abkf_div.sv
// Restoring divider, one quotient bit per cycle: (num + den/2) / den.
// Depends on abkf_pkg.
`default_nettype none
module abkf_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       num,
  input  wire logic [32:0]       den,
  output      logic              done,
  output      logic [47:0]       quo
);
  import abkf_pkg::*;
  logic [63:0] dvd;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] trial;

  always_comb trial = {rem, dvd[63]} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= num + 64'(den >> 1);
        rem  <= '0;
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        // quotient fits in 48 bits: num <= 2^47, den >= 1
        if (!trial[34]) rem <= trial[33:0];
        else rem <= {rem[32:0], dvd[63]};
        quo <= {quo[46:0], ~trial[34]};
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
